FILE: hdl/uer_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types, register codes and reset values for the ranger and its step
// logic.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Number of sensor channels served by the block.
  localparam int CHANNELS = 4;
  localparam int CH_W     = 2;
  localparam int TICK_W   = 16;
  localparam int DIST_W   = 15;

  // Width of the input and output stream words.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  // Register reset values.
  localparam logic [7:0]  PRE_LOW_RST   = 8'd2;
  localparam logic [7:0]  TRIG_HIGH_RST = 8'd10;
  localparam logic [15:0] RISE_TO_RST   = 16'd10000;
  localparam logic [15:0] HIGH_TO_RST   = 16'd30000;

  // count*16/58 = count*8/29. floor(count*8/29) equals
  // floor(count*DIST_RECIP / 2^22) for every count up to 65536,
  // where DIST_RECIP = ceil(2^25 / 29).
  localparam int                 DIST_RECIP_W = 21;
  localparam logic [20:0]        DIST_RECIP   = 21'd1157050;
  localparam int                 DIST_SHIFT   = 22;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRE_LOW   = 2'd0,
    CFG_TRIG_HIGH = 2'd1,
    CFG_RISE_TO   = 2'd2,
    CFG_HIGH_TO   = 2'd3
  } uer_cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PRE_LOW   = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_MEASURE   = 3'd4
  } uer_phase_e;

  typedef struct packed {
    logic [7:0]  pre_low;
    logic [7:0]  trig_high;
    logic [15:0] rise_to;
    logic [15:0] high_to;
  } uer_cfg_t;

  typedef struct packed {
    uer_phase_e        phase;
    logic [TICK_W-1:0] tick;
    logic [CH_W-1:0]   active;
  } uer_state_t;

  typedef struct packed {
    logic                start_req;
    logic [CH_W-1:0]     channel;
    logic [CHANNELS-1:0] echo_levels;
  } uer_item_t;

  typedef struct packed {
    logic [CHANNELS-1:0] trigger_levels;
    logic                busy_res;
    logic                done_res;
    logic                timed_out;
    logic [DIST_W-1:0]   distance_sixteenths;
    logic [CH_W-1:0]     result_channel;
  } uer_res_t;

endpackage

FILE: hdl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger and echo timing for four pulse-echo range sensors, one tick a request.
// ----------------------------------------------------------------------------
// A request passes through the input register and then the result register.
// Throughput: one request per cycle, sustained, while the output side accepts.
// Reset (rst_ni low, asynchronous): both stages empty, phase idle, tick count
// and active channel zero, configuration registers at their default values.
module ultrasonic_echo_ranger (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // Tick request stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // From bit 0: start_req, channel[1:0], echo_levels[3:0], one zero pad bit.
  input  logic [uer_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // From bit 0: trigger_levels[3:0], busy_res, done_res, timed_out,
  // distance_sixteenths[14:0], result_channel[1:0].
  output logic [uer_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  uer_pkg::uer_cfg_t   cfg_q;
  uer_pkg::uer_state_t state_q;
  uer_pkg::uer_state_t state_d;
  uer_pkg::uer_item_t  in_q;
  uer_pkg::uer_res_t   res;
  logic                in_vld_q;
  logic                out_vld_q;
  logic [uer_pkg::OUT_TDATA_W-1:0] out_q;
  logic                adv;

  // Configuration registers. Write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_low   <= uer_pkg::PRE_LOW_RST;
      cfg_q.trig_high <= uer_pkg::TRIG_HIGH_RST;
      cfg_q.rise_to   <= uer_pkg::RISE_TO_RST;
      cfg_q.high_to   <= uer_pkg::HIGH_TO_RST;
    end else if (cfg_we_i) begin
      unique case (uer_pkg::uer_cfg_idx_e'(cfg_idx_i))
        uer_pkg::CFG_PRE_LOW:   cfg_q.pre_low   <= cfg_wdata_i[7:0];
        uer_pkg::CFG_TRIG_HIGH: cfg_q.trig_high <= cfg_wdata_i[7:0];
        uer_pkg::CFG_RISE_TO:   cfg_q.rise_to   <= cfg_wdata_i;
        uer_pkg::CFG_HIGH_TO:   cfg_q.high_to   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The request in the input register is processed when the result register
  // is empty or is being drained in this cycle. The input register reloads in
  // the same cycle, so a request can be taken every cycle while results drain;
  // while a result waits for the downstream side, the input register holds.
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.start_req   <= s_axis_tdata[0];
      in_q.channel     <= s_axis_tdata[2:1];
      in_q.echo_levels <= s_axis_tdata[6:3];
    end
  end

  // Measurement state advances exactly once per processed request.
  uer_step u_step (
    .item_i  (in_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase  <= uer_pkg::PH_IDLE;
      state_q.tick   <= '0;
      state_q.active <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {res.result_channel, res.distance_sixteenths, res.timed_out,
                res.done_res, res.busy_res, res.trigger_levels};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: hdl/uer_step.sv
// ----------------------------------------------------------------------------
// Ranger step logic
// Next state and result for one microsecond tick, purely combinational.
// ----------------------------------------------------------------------------
module uer_step (
  input  uer_pkg::uer_item_t  item_i,
  input  uer_pkg::uer_state_t state_i,
  input  uer_pkg::uer_cfg_t   cfg_i,
  output uer_pkg::uer_state_t state_o,
  output uer_pkg::uer_res_t   res_o
);

  logic                              level;
  logic                              done;
  logic                              fail;
  logic [uer_pkg::CH_W-1:0]          res_ch;
  logic [uer_pkg::TICK_W:0]          elapsed;
  logic [uer_pkg::TICK_W-1:0]        tick_inc;
  logic [uer_pkg::TICK_W+uer_pkg::DIST_RECIP_W:0] prod;
  uer_pkg::uer_state_t               nxt;

  assign level    = item_i.echo_levels[state_i.active];
  assign elapsed  = {1'b0, state_i.tick} + 17'd1;
  assign tick_inc = elapsed[uer_pkg::TICK_W-1:0];
  assign prod     = 38'(elapsed) * 38'(uer_pkg::DIST_RECIP);

  always_comb begin
    nxt    = state_i;
    done   = 1'b0;
    fail   = 1'b0;
    res_ch = '0;
    unique case (state_i.phase)
      uer_pkg::PH_IDLE: begin
        if (item_i.start_req) begin
          if (32'(item_i.channel) >= uer_pkg::CHANNELS) begin
            done   = 1'b1;
            fail   = 1'b1;
            res_ch = item_i.channel;
          end else begin
            nxt.active = item_i.channel;
            nxt.tick   = '0;
            nxt.phase  = (cfg_i.pre_low == 8'd0) ? uer_pkg::PH_TRIG_HIGH
                                                 : uer_pkg::PH_PRE_LOW;
          end
        end
      end
      uer_pkg::PH_PRE_LOW: begin
        nxt.tick = tick_inc;
        if (tick_inc >= {8'd0, cfg_i.pre_low}) begin
          nxt.phase = uer_pkg::PH_TRIG_HIGH;
          nxt.tick  = '0;
        end
      end
      uer_pkg::PH_TRIG_HIGH: begin
        nxt.tick = tick_inc;
        if (tick_inc >= {8'd0, cfg_i.trig_high}) begin
          nxt.phase = uer_pkg::PH_WAIT_RISE;
          nxt.tick  = '0;
        end
      end
      uer_pkg::PH_WAIT_RISE: begin
        if (level) begin
          nxt.phase = uer_pkg::PH_MEASURE;
          nxt.tick  = '0;
        end else if (elapsed > {1'b0, cfg_i.rise_to}) begin
          done = 1'b1;
          fail = 1'b1;
        end else begin
          nxt.tick = tick_inc;
        end
      end
      uer_pkg::PH_MEASURE: begin
        if (!level) begin
          done = 1'b1;
        end else if (elapsed > {1'b0, cfg_i.high_to}) begin
          done = 1'b1;
          fail = 1'b1;
        end else begin
          nxt.tick = tick_inc;
        end
      end
      default: begin
        nxt.phase = uer_pkg::PH_IDLE;
        nxt.tick  = '0;
      end
    endcase

    // A measurement that ends returns to idle and reports its channel.
    if (done && (nxt.phase != uer_pkg::PH_IDLE)) begin
      res_ch    = state_i.active;
      nxt.phase = uer_pkg::PH_IDLE;
      nxt.tick  = '0;
    end
  end

  assign state_o = nxt;

  always_comb begin
    res_o.trigger_levels = (nxt.phase == uer_pkg::PH_TRIG_HIGH)
                         ? (uer_pkg::CHANNELS'(1) << nxt.active) : '0;
    res_o.busy_res       = (nxt.phase != uer_pkg::PH_IDLE);
    res_o.done_res       = done;
    res_o.timed_out      = done && fail;
    res_o.distance_sixteenths = (done && !fail)
        ? prod[uer_pkg::DIST_SHIFT +: uer_pkg::DIST_W] : '0;
    res_o.result_channel = res_ch;
  end

endmodule

FILE: hdl/uer_checker.sv
// ----------------------------------------------------------------------------
// Ranger port checker
// Concurrent checks on the result stream of the ranger, bound to its top level.
// ----------------------------------------------------------------------------
module uer_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [uer_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [3:0]  trig;
  logic        busy;
  logic        done;
  logic        tmo;
  logic [14:0] distance;

  assign trig     = m_axis_tdata[3:0];
  assign busy     = m_axis_tdata[4];
  assign done     = m_axis_tdata[5];
  assign tmo      = m_axis_tdata[6];
  assign distance = m_axis_tdata[21:7];

  // A stalled result holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A finished measurement leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && done |-> !busy && (trig == 4'd0))
    else $error("busy or trigger active on the ending tick");

  // The trigger drives one channel only, and only during a measurement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (trig != 4'd0) |-> busy && $onehot(trig))
    else $error("bad trigger drive");

  // A timeout or a distance only comes with done, and never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (tmo || (distance != 15'd0))
      |-> done && !(tmo && (distance != 15'd0)))
    else $error("timeout or distance without a clean done");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
